[rtl/ansp_pkg.sv]
// Shared constants and types for the notification stream parser.
`default_nettype none

package ansp_pkg;

    // FILETIME ticks between 1601-01-01 and 1970-01-01
    localparam logic [63:0] FT_EPOCH_OFFSET  = 64'd116444736000000000;
    localparam logic [16:0] STAMP_HDR_BYTES  = 17'd12;
    localparam logic [16:0] SAMPLE_HDR_BYTES = 17'd8;
    localparam logic [15:0] MIN_FRAME_BYTES  = 16'd8;

    typedef struct packed {
        logic [31:0] notify_handle;
        logic [63:0] stamp_ns;
        logic [7:0]  sample_byte;
        logic        sample_first;
        logic        sample_last;
        logic        sample_empty;
    } result_t;

endpackage

`default_nettype wire

[rtl/ansp_stamp_conv.sv]
// FILETIME to Unix nanoseconds converter, four register stages, times 100 by shift and add.
`default_nettype none

module ansp_stamp_conv (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        kill,
    input  wire logic        start,
    input  wire logic [63:0] filetime,
    output logic [63:0]      stamp_ns
);
    import ansp_pkg::*;

    logic        v_a_reg, v_b_reg, v_c_reg;
    logic [63:0] ft_a_reg;
    logic [63:0] diff_b_reg;
    logic [63:0] diff_c_reg;
    logic [63:0] part_c_reg;
    logic [63:0] stamp_reg;
    logic [63:0] diff_next;
    logic [63:0] stamp_next;

    // below the epoch offset the stamp is zero
    assign diff_next  = (ft_a_reg >= FT_EPOCH_OFFSET) ? (ft_a_reg - FT_EPOCH_OFFSET) : 64'd0;
    // x*100 = x*64 + x*32 + x*4
    assign stamp_next = part_c_reg + (diff_c_reg << 2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg   <= 1'b0;
            v_b_reg   <= 1'b0;
            v_c_reg   <= 1'b0;
            stamp_reg <= 64'd0;
        end
        else if (kill)
        begin
            v_a_reg   <= 1'b0;
            v_b_reg   <= 1'b0;
            v_c_reg   <= 1'b0;
            stamp_reg <= 64'd0;
        end
        else
        begin
            v_a_reg <= start;
            v_b_reg <= v_a_reg;
            v_c_reg <= v_b_reg;
            if (v_c_reg)
            begin
                stamp_reg <= stamp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ft_a_reg <= filetime;
        end
        diff_b_reg <= diff_next;
        diff_c_reg <= diff_b_reg;
        part_c_reg <= (diff_b_reg << 6) + (diff_b_reg << 5);
    end

    assign stamp_ns = stamp_reg;

endmodule

`default_nettype wire

[rtl/ansp_parser.sv]
// Byte-wise header and sample parser state machine.
`default_nettype none

module ansp_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_fire,
    input  wire logic [7:0]       data_byte,
    input  wire logic [15:0]      frame_length,
    input  wire logic             frame_start,
    input  wire logic [63:0]      cur_stamp,
    output logic                  kill,
    output logic                  conv_start,
    output logic [63:0]           conv_ft,
    output logic                  res_valid,
    output ansp_pkg::result_t     res
);
    import ansp_pkg::*;

    localparam logic [2:0] PH_SKIP          = 3'd0;
    localparam logic [2:0] PH_COUNT         = 3'd1;
    localparam logic [2:0] PH_STAMP_FT      = 3'd2;
    localparam logic [2:0] PH_STAMP_NS      = 3'd3;
    localparam logic [2:0] PH_SAMPLE_HANDLE = 3'd4;
    localparam logic [2:0] PH_SAMPLE_SIZE   = 3'd5;
    localparam logic [2:0] PH_DATA          = 3'd6;

    logic [2:0]  phase_reg,   phase_next;
    logic [15:0] pos_reg,     pos_next;
    logic [2:0]  idx_reg,     idx_next;
    logic [31:0] stamps_reg,  stamps_next;
    logic [31:0] samples_reg, samples_next;
    logic [63:0] ftg_reg,     ftg_next;
    logic [31:0] handle_reg,  handle_next;
    logic [31:0] brem_reg,    brem_next;
    logic        halted_reg,  halted_next;
    logic        stop;
    logic        emit;
    logic        ft_done;
    logic [16:0] pos17, len17;

    always_comb
    begin
        phase_next   = frame_start ? PH_SKIP : phase_reg;
        pos_next     = frame_start ? 16'd0   : pos_reg;
        idx_next     = frame_start ? 3'd0    : idx_reg;
        stamps_next  = frame_start ? 32'd0   : stamps_reg;
        samples_next = frame_start ? 32'd0   : samples_reg;
        ftg_next     = frame_start ? 64'd0   : ftg_reg;
        handle_next  = frame_start ? 32'd0   : handle_reg;
        brem_next    = frame_start ? 32'd0   : brem_reg;
        halted_next  = frame_start ? 1'b0    : halted_reg;
        pos17        = {1'b0, pos_next};
        len17        = {1'b0, frame_length};
        stop         = 1'b0;
        emit         = 1'b0;
        ft_done      = 1'b0;
        res.notify_handle = handle_next;
        res.stamp_ns      = cur_stamp;
        res.sample_byte   = data_byte;
        res.sample_first  = 1'b0;
        res.sample_last   = 1'b0;
        res.sample_empty  = 1'b0;

        if (!halted_next)
        begin
            if (pos_next >= frame_length || frame_length < MIN_FRAME_BYTES)
            begin
                halted_next = 1'b1;
            end
            else
            begin
                // header starts: check room before committing
                if (phase_next == PH_SAMPLE_HANDLE && idx_next == 3'd0)
                begin
                    if (samples_next == 32'd0)
                    begin
                        phase_next = PH_STAMP_FT;
                    end
                    else if (pos17 + SAMPLE_HDR_BYTES > len17)
                    begin
                        halted_next = 1'b1;
                        stop        = 1'b1;
                    end
                    else
                    begin
                        samples_next = samples_next - 32'd1;
                        handle_next  = 32'd0;
                    end
                end
                if (!stop && phase_next == PH_STAMP_FT && idx_next == 3'd0)
                begin
                    if (stamps_next == 32'd0 || pos17 + STAMP_HDR_BYTES > len17)
                    begin
                        halted_next = 1'b1;
                        stop        = 1'b1;
                    end
                    else
                    begin
                        stamps_next = stamps_next - 32'd1;
                        ftg_next    = 64'd0;
                    end
                end

                if (!stop)
                begin
                    unique case (phase_next)
                        PH_SKIP:
                        begin
                            idx_next = idx_next + 3'd1;
                            if (idx_next == 3'd4)
                            begin
                                idx_next    = 3'd0;
                                stamps_next = 32'd0;
                                phase_next  = PH_COUNT;
                            end
                        end
                        PH_COUNT:
                        begin
                            stamps_next[{idx_next[1:0], 3'b000} +: 8] = data_byte;
                            if (idx_next == 3'd3)
                            begin
                                idx_next   = 3'd0;
                                phase_next = PH_STAMP_FT;
                            end
                            else
                            begin
                                idx_next = idx_next + 3'd1;
                            end
                        end
                        PH_STAMP_FT:
                        begin
                            ftg_next[{idx_next, 3'b000} +: 8] = data_byte;
                            if (idx_next == 3'd7)
                            begin
                                ft_done      = 1'b1;
                                idx_next     = 3'd0;
                                samples_next = 32'd0;
                                phase_next   = PH_STAMP_NS;
                            end
                            else
                            begin
                                idx_next = idx_next + 3'd1;
                            end
                        end
                        PH_STAMP_NS:
                        begin
                            samples_next[{idx_next[1:0], 3'b000} +: 8] = data_byte;
                            if (idx_next == 3'd3)
                            begin
                                idx_next   = 3'd0;
                                phase_next = PH_SAMPLE_HANDLE;
                            end
                            else
                            begin
                                idx_next = idx_next + 3'd1;
                            end
                        end
                        PH_SAMPLE_HANDLE:
                        begin
                            handle_next[{idx_next[1:0], 3'b000} +: 8] = data_byte;
                            if (idx_next == 3'd3)
                            begin
                                idx_next   = 3'd0;
                                brem_next  = 32'd0;
                                phase_next = PH_SAMPLE_SIZE;
                            end
                            else
                            begin
                                idx_next = idx_next + 3'd1;
                            end
                        end
                        PH_SAMPLE_SIZE:
                        begin
                            brem_next[{idx_next[1:0], 3'b000} +: 8] = data_byte;
                            if (idx_next == 3'd3)
                            begin
                                idx_next = 3'd0;
                                if ({16'd0, pos17} + 33'd1 + {1'b0, brem_next}
                                    > {16'd0, len17})
                                begin
                                    halted_next = 1'b1;
                                end
                                else if (brem_next == 32'd0)
                                begin
                                    // empty sample marker
                                    emit             = 1'b1;
                                    res.sample_byte  = 8'd0;
                                    res.sample_first = 1'b1;
                                    res.sample_last  = 1'b1;
                                    res.sample_empty = 1'b1;
                                    phase_next       = PH_SAMPLE_HANDLE;
                                end
                                else
                                begin
                                    idx_next   = 3'd1;  // first data byte flag
                                    phase_next = PH_DATA;
                                end
                            end
                            else
                            begin
                                idx_next = idx_next + 3'd1;
                            end
                        end
                        default:
                        begin
                            emit             = 1'b1;
                            res.sample_first = (idx_next != 3'd0);
                            res.sample_last  = (brem_next <= 32'd1);
                            idx_next         = 3'd0;
                            if (brem_next != 32'd0)
                            begin
                                brem_next = brem_next - 32'd1;
                            end
                            if (brem_next == 32'd0)
                            begin
                                phase_next = PH_SAMPLE_HANDLE;
                            end
                        end
                    endcase
                    pos_next = pos_next + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_SKIP;
            pos_reg     <= 16'd0;
            idx_reg     <= 3'd0;
            stamps_reg  <= 32'd0;
            samples_reg <= 32'd0;
            ftg_reg     <= 64'd0;
            handle_reg  <= 32'd0;
            brem_reg    <= 32'd0;
            halted_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            idx_reg     <= idx_next;
            stamps_reg  <= stamps_next;
            samples_reg <= samples_next;
            ftg_reg     <= ftg_next;
            handle_reg  <= handle_next;
            brem_reg    <= brem_next;
            halted_reg  <= halted_next;
        end
    end

    assign kill       = in_fire & frame_start;
    assign conv_start = in_fire & ft_done;
    assign conv_ft    = ftg_next;
    assign res_valid  = in_fire & emit;

endmodule

`default_nettype wire

[rtl/ads_notification_stream_parser_top.sv]
// Top level of the notification stream parser: parser, stamp converter, output register.
`default_nettype none

// Notification stream parser.
// Input channel (in_valid/in_ready): one beat per byte of a notification
// frame's data part, with frame_length (constant over the frame) and
// frame_start set on the first byte, which restarts the parser.
// Output channel (out_valid/out_ready): one beat per sample byte, or one
// empty marker for a zero-size sample, with its handle and timestamp in ns.
// Most input beats (headers, skipped or ignored bytes) give no output beat.
// Throughput: one input beat per cycle unless the output stalls; the byte
// parser is a combinational state update from input accept to output register.
// Latency: an output beat appears in the cycle after its input beat.
// The timestamp (FILETIME - offset) * 100 is built by a four-stage converter
// that finishes well before the first sample of that stamp, since at least
// twelve header bytes follow the last FILETIME byte.
// Reset: the parser starts in the stream-length skip with all counters clear
// and the output register empty.
// Receiver stall: the output register holds its beat; in_ready stays high
// only while the register is empty or being drained, so nothing is lost.
module ads_notification_stream_parser_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic [15:0] frame_length,
    input  wire logic        frame_start,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      notify_handle,
    output logic [63:0]      stamp_ns,
    output logic [7:0]       sample_byte,
    output logic             sample_first,
    output logic             sample_last,
    output logic             sample_empty
);
    import ansp_pkg::*;

    logic        in_fire;
    logic        kill;
    logic        conv_start;
    logic [63:0] conv_ft;
    logic [63:0] cur_stamp;
    logic        res_valid;
    result_t     res;
    result_t     out_reg;
    logic        out_valid_reg, out_valid_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    ansp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .data_byte    (data_byte),
        .frame_length (frame_length),
        .frame_start  (frame_start),
        .cur_stamp    (cur_stamp),
        .kill         (kill),
        .conv_start   (conv_start),
        .conv_ft      (conv_ft),
        .res_valid    (res_valid),
        .res          (res)
    );

    // frame restart zeroes the current stamp and drops any conversion in flight
    ansp_stamp_conv u_stamp_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .kill     (kill),
        .start    (conv_start),
        .filetime (conv_ft),
        .stamp_ns (cur_stamp)
    );

    // output beat register: new result loads, otherwise hold until taken
    assign out_valid_next = res_valid || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign notify_handle = out_reg.notify_handle;
    assign stamp_ns      = out_reg.stamp_ns;
    assign sample_byte   = out_reg.sample_byte;
    assign sample_first  = out_reg.sample_first;
    assign sample_last   = out_reg.sample_last;
    assign sample_empty  = out_reg.sample_empty;

endmodule

`default_nettype wire
